[rtl/text_console_writer_assert.svh]
// Assertion macros used by the console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked on every rising edge outside reset.
`define TCW_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define TCW_ASSERT(name, clk, rst, prop, msg)
`define TCW_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

[rtl/tcw_pkg.sv]
package tcw_pkg;

   // Screen geometry.
   localparam int COLS     = 80;
   localparam int ROWS     = 25;
   localparam int TAB_STEP = 8;
   localparam int CELLS    = ROWS * COLS;

   localparam int COL_W  = $clog2(COLS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int ADDR_W = $clog2(CELLS);
   // Wide enough for a column after a tab or an increment, before the wrap.
   localparam int NCOL_W = $clog2(COLS + TAB_STEP + 1);
   localparam int NROW_W = ROW_W + 1;

   // Fixed field widths of the channels.
   localparam int CHAR_W    = 8;
   localparam int ATTR_W    = 8;
   localparam int CELL_W    = CHAR_W + ATTR_W;
   localparam int IN_ROW_W  = 5;
   localparam int IN_COL_W  = 7;
   localparam int OUT_COL_W = 7;
   localparam int OUT_ROW_W = 5;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 32;
   localparam int REQ_PAD_W  = REQ_DATA_W - (CHAR_W + ATTR_W + IN_ROW_W + IN_COL_W);
   localparam int RSP_PAD_W  = RSP_DATA_W - (CHAR_W + ATTR_W + OUT_COL_W + OUT_ROW_W);

   // Configuration port.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BG_ATTR = 1'd1;

   // Request kinds carried in tuser.
   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   // Character codes.
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_LO  = 8'h20;
   localparam logic [CHAR_W-1:0] CH_PRINT_HI  = 8'h7E;

   // Operations decided by the front end.
   typedef logic [2:0] op_type;
   localparam op_type OP_NOP       = 3'd0;
   localparam op_type OP_PRINT     = 3'd1;
   localparam op_type OP_TAB       = 3'd2;
   localparam op_type OP_NEWLINE   = 3'd3;
   localparam op_type OP_BACKSPACE = 3'd4;
   localparam op_type OP_READ      = 3'd5;
   localparam op_type OP_READ_NONE = 3'd6;

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      op_type              op;
      logic [CHAR_W-1:0]   char_code;
      logic [ATTR_W-1:0]   color;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
   } cmd_type;

   typedef struct packed {
      logic                clearing;
      logic [ROW_W-1:0]    top_line;
   } status_type;

endpackage

[rtl/tcw_front.sv]
module tcw_front
   import tcw_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] char_code, [15:8] color, [20:16] read_row, [27:21] read_col
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                  req_tuser,
   input  logic                  enabled,
   input  status_type            status,
   output logic                  push_valid,
   input  logic                  push_ready,
   output cmd_type               push_cmd
);

   logic [CHAR_W-1:0]   char_code;
   logic [ATTR_W-1:0]   color;
   logic [IN_ROW_W-1:0] read_row;
   logic [IN_COL_W-1:0] read_col;

   assign char_code = req_tdata[CHAR_W-1:0];
   assign color     = req_tdata[CHAR_W+ATTR_W-1:CHAR_W];
   assign read_row  = req_tdata[CHAR_W+ATTR_W+IN_ROW_W-1:CHAR_W+ATTR_W];
   assign read_col  = req_tdata[CHAR_W+ATTR_W+IN_ROW_W+IN_COL_W-1:CHAR_W+ATTR_W+IN_ROW_W];

   // No item enters while the screen store is being cleared after reset.
   assign req_tready = push_ready && !status.clearing;
   assign push_valid = req_tvalid && !status.clearing;

   always_comb begin
      push_cmd           = '0;
      push_cmd.char_code = char_code;
      push_cmd.color     = color;
      if (req_tuser == FUNC_READ) begin
         if ((32'(read_row) < ROWS) && (32'(read_col) < COLS)) begin
            push_cmd.op  = OP_READ;
            push_cmd.row = ROW_W'(read_row);
            push_cmd.col = COL_W'(read_col);
         end else begin
            push_cmd.op = OP_READ_NONE;
         end
      end else if (!enabled) begin
         push_cmd.op = OP_NOP;
      end else if ((char_code >= CH_PRINT_LO) && (char_code <= CH_PRINT_HI)) begin
         push_cmd.op = OP_PRINT;
      end else begin
         case (char_code)
            CH_TAB:       push_cmd.op = OP_TAB;
            CH_NEWLINE:   push_cmd.op = OP_NEWLINE;
            CH_BACKSPACE: push_cmd.op = OP_BACKSPACE;
            default:      push_cmd.op = OP_NOP;
         endcase
      end
   end

endmodule

[rtl/tcw_queue.sv]
module tcw_queue
   import tcw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [Q_IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_IDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 push, pop;

   assign push_ready = 32'(count_ff) < QUEUE_DEPTH;
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[rtl/tcw_back.sv]
module tcw_back
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  cmd_type               pop_cmd,
   input  logic [ATTR_W-1:0]     background_attr,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output status_type            status
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_READ   = 2'd2;
   localparam logic [1:0] ST_SCROLL = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      line_ff, line_in;
   logic [ROW_W-1:0]      top_ff, top_in;
   logic [ADDR_W-1:0]     sweep_ff, sweep_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [ATTR_W-1:0]     rsp_attr_ff, rsp_attr_in;
   logic [COL_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]      rsp_row_ff, rsp_row_in;

   logic [CELL_W-1:0]     mem [CELLS];
   logic [CELL_W-1:0]     mem_q;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [CELL_W-1:0]     wr_data;
   logic [ADDR_W-1:0]     rd_addr;

   logic                  out_free;
   logic                  start;
   logic                  is_put;
   logic [NCOL_W-1:0]     col_nx;
   logic [NROW_W-1:0]     line_nx;
   logic                  put_wr;
   logic [ROW_W-1:0]      pos_line;
   logic [COL_W-1:0]      pos_col;
   logic [CHAR_W-1:0]     put_char;
   logic                  need_scroll;
   logic [ADDR_W-1:0]     top_base;

   // Screen row r lives at store line (top + r) mod ROWS.
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] top,
                                                    input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
      logic [ROW_W:0] sum;
      sum = {1'b0, top} + {1'b0, row};
      if (32'(sum) >= ROWS) begin
         sum = sum - (ROW_W+1)'(ROWS);
      end
      return ADDR_W'(ADDR_W'(sum[ROW_W-1:0]) * ADDR_W'(COLS)) + ADDR_W'(col);
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign start     = (state_ff == ST_RUN) && pop_valid && out_free;
   assign pop_ready = start;
   assign top_base  = ADDR_W'(ADDR_W'(top_ff) * ADDR_W'(COLS));
   assign rd_addr   = cell_addr(top_ff, pop_cmd.row, pop_cmd.col);

   // Cursor movement of a put item.
   always_comb begin
      col_nx      = NCOL_W'(col_ff);
      line_nx     = NROW_W'(line_ff);
      put_wr      = 1'b0;
      pos_line    = line_ff;
      pos_col     = col_ff;
      put_char    = pop_cmd.char_code;
      need_scroll = 1'b0;
      is_put      = 1'b0;
      case (pop_cmd.op)
         OP_PRINT: begin
            is_put = 1'b1;
            put_wr = 1'b1;
            col_nx = NCOL_W'(col_ff) + NCOL_W'(1);
         end
         OP_TAB: begin
            is_put = 1'b1;
            col_nx = NCOL_W'(col_ff) - NCOL_W'(col_ff % TAB_STEP) + NCOL_W'(TAB_STEP);
         end
         OP_NEWLINE: begin
            is_put  = 1'b1;
            col_nx  = '0;
            line_nx = NROW_W'(line_ff) + NROW_W'(1);
         end
         OP_BACKSPACE: begin
            is_put   = 1'b1;
            put_char = CH_SPACE;
            // At the origin a backspace leaves everything as it is.
            if (col_ff != '0) begin
               put_wr  = 1'b1;
               col_nx  = NCOL_W'(col_ff) - NCOL_W'(1);
               pos_col = col_ff - 1'b1;
            end else if (line_ff != '0) begin
               put_wr   = 1'b1;
               col_nx   = NCOL_W'(COLS - 1);
               line_nx  = NROW_W'(line_ff) - NROW_W'(1);
               pos_col  = COL_W'(COLS - 1);
               pos_line = line_ff - 1'b1;
            end
         end
         default: begin
            is_put = 1'b0;
         end
      endcase
      if (32'(col_nx) >= COLS) begin
         col_nx  = '0;
         line_nx = line_nx + NROW_W'(1);
      end
      if (32'(line_nx) >= ROWS) begin
         need_scroll = 1'b1;
         line_nx     = NROW_W'(ROWS - 1);
      end
   end

   // Single write port: clearing pass, line clear of a scroll, or a put.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = sweep_ff;
      wr_data = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_SCROLL: begin
            wr_en   = 1'b1;
            wr_data = {background_attr, {CHAR_W{1'b0}}};
         end
         ST_RUN: begin
            wr_en   = start && put_wr;
            wr_addr = cell_addr(top_ff, pos_line, pos_col);
            wr_data = {pop_cmd.color, put_char};
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      mem_q <= mem[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      line_in      = line_ff;
      top_in       = top_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_attr_in  = rsp_attr_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      case (state_ff)
         ST_CLEAR: begin
            sweep_in = sweep_ff + 1'b1;
            if (32'(sweep_ff) == CELLS - 1) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (start) begin
               rsp_char_in = '0;
               rsp_attr_in = '0;
               if (pop_cmd.op == OP_READ) begin
                  state_in = ST_READ;
               end else begin
                  if (is_put) begin
                     col_in  = COL_W'(col_nx);
                     line_in = ROW_W'(line_nx);
                  end
                  rsp_col_in = is_put ? COL_W'(col_nx) : col_ff;
                  rsp_row_in = is_put ? ROW_W'(line_nx) : line_ff;
                  if (need_scroll) begin
                     // The result waits until the old top line is cleared.
                     state_in = ST_SCROLL;
                     sweep_in = top_base;
                  end else begin
                     rsp_valid_in = 1'b1;
                  end
               end
            end
         end
         ST_READ: begin
            state_in     = ST_RUN;
            rsp_valid_in = 1'b1;
            rsp_char_in  = mem_q[CHAR_W-1:0];
            rsp_attr_in  = mem_q[CELL_W-1:CHAR_W];
            rsp_col_in   = col_ff;
            rsp_row_in   = line_ff;
         end
         ST_SCROLL: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == top_base + ADDR_W'(COLS - 1)) begin
               state_in     = ST_RUN;
               top_in       = (32'(top_ff) == ROWS - 1) ? '0 : top_ff + 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         col_ff       <= '0;
         line_ff      <= '0;
         top_ff       <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         top_ff       <= top_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, OUT_ROW_W'(rsp_row_ff), OUT_COL_W'(rsp_col_ff),
                        rsp_attr_ff, rsp_char_ff};

   assign status.clearing = state_ff == ST_CLEAR;
   assign status.top_line = top_ff;

endmodule

[rtl/text_console_writer.sv]
// Text console writer.
// Items arrive on the req_ stream: tuser selects a put (0) or a cell read (1),
// tdata carries the character, its attribute and, for a read, the screen row
// and column. Every item gives one result on the rsp_ stream with the read
// cell (zero for a put) and the cursor position after the item.
// The csr_ port writes register 0 (enable for puts) and register 1 (attribute
// of lines cleared by a scroll); it is always ready.
// Accepted items pass a two-entry queue before execution, so input keeps
// flowing while a result waits on a stalled receiver; the receiver stalling
// holds the result register and, once the queue fills, req_tready drops.
// A put passes the queue slot and the result register, a read also the store
// read register and the READ state; a put that scrolls waits in the SCROLL state
// for the single-port line clear. Puts run at one per cycle while rsp_tready
// stays high; a read or a scroll holds the execution stage until it is done.
// After reset the screen store is cleared one cell per cycle, all ROWS * COLS
// (2000) cells, with req_tready low; the cursor and top line return to zero.
`include "text_console_writer_assert.svh"

module text_console_writer
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] char_code, [15:8] color, [20:16] read_row, [27:21] read_col
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] func
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic              enabled_ff, enabled_in;
   logic [ATTR_W-1:0] bg_attr_ff, bg_attr_in;
   status_type        status;
   logic              push_valid, push_ready;
   cmd_type           push_cmd;
   logic              pop_valid, pop_ready;
   cmd_type           pop_cmd;

   assign csr_ready = 1'b1;

   always_comb begin
      enabled_in = enabled_ff;
      bg_attr_in = bg_attr_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLED: enabled_in = csr_data[0];
            CSR_BG_ATTR: bg_attr_in = ATTR_W'(csr_data);
            default:     enabled_in = enabled_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         bg_attr_ff <= '0;
      end else begin
         enabled_ff <= enabled_in;
         bg_attr_ff <= bg_attr_in;
      end
   end

   tcw_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .enabled    (enabled_ff),
      .status     (status),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   tcw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   tcw_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_cmd         (pop_cmd),
      .background_attr (bg_attr_ff),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .status          (status)
   );

   `TCW_ASSERT_ALWAYS(a_reset_starts_clear, clock, reset |=> status.clearing, "no clear pass after reset")
   `TCW_ASSERT(a_clear_blocks_input, clock, reset, status.clearing |-> !req_tready, "input open during clear")
   `TCW_ASSERT(a_clear_no_result, clock, reset, status.clearing |-> !rsp_tvalid, "result during clear")
   `TCW_ASSERT(a_top_in_range, clock, reset, 32'(status.top_line) < ROWS, "top line out of range")

endmodule
